// ===== design/audio_waveform_oscillator_macros.svh =====
`ifndef AUDIO_WAVEFORM_OSCILLATOR_MACROS_SVH
`define AUDIO_WAVEFORM_OSCILLATOR_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define AWO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/awo_pkg.sv =====
package awo_pkg;

    localparam int MAX_HARMONICS = 64;

    localparam int INDEX_W   = 32;
    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 17;
    localparam int MODE_W    = 3;
    localparam int LIMREG_W  = 7;

    localparam int IDX_W     = $clog2(MAX_HARMONICS);
    localparam int NCNT_W    = $clog2(MAX_HARMONICS + 1);
    localparam int LIM_W     = (NCNT_W > LIMREG_W) ? NCNT_W : LIMREG_W;

    localparam int RECIP_W   = 25;
    localparam int SCALE_W   = 16;
    localparam int TERM_W    = SCALE_W + RECIP_W;
    localparam int MAG_W     = IDX_W + 39;
    localparam int ACC_W     = MAG_W + 2;
    localparam int SC_LO_W   = 23;
    localparam int SC_HI_W   = MAG_W - SC_LO_W;
    localparam int SC_LO_P_W = SCALE_W + SC_LO_W;
    localparam int SC_HI_P_W = SCALE_W + SC_HI_W;
    localparam int SUM_W     = MAG_W + SCALE_W + 1;
    localparam int RND_SH    = 40;
    localparam int RND_W     = SUM_W - RND_SH;

    localparam logic [SCALE_W-1:0] SAW_SCALE = 16'd41722;
    localparam logic [31:0] NOISE_SEED = 32'hACE1ACE1;
    localparam logic [31:0] NOISE_TAPS = 32'h80200003;
    localparam int OUT_MAX = 65535;
    localparam int OUT_NEG_MAX = 65536;

    localparam logic [MODE_W-1:0] MODE_SILENT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SINE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRI    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOISE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SAW    = 3'd5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM  = 2'd2;

    localparam logic [MODE_W-1:0]   RST_MODE = MODE_SILENT;
    localparam logic [PHASE_W-1:0]  RST_INC  = 32'd683565276;
    localparam logic [LIMREG_W-1:0] RST_LIM  = 7'd50;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_IDLE     = 4'd0;
    localparam t_step S_PHASE    = 4'd1;
    localparam t_step S_SINE     = 4'd2;
    localparam t_step S_SINE_RES = 4'd3;
    localparam t_step S_SQR      = 4'd4;
    localparam t_step S_SQR_RES  = 4'd5;
    localparam t_step S_TRI      = 4'd6;
    localparam t_step S_NOISE    = 4'd7;
    localparam t_step S_ZERO     = 4'd8;
    localparam t_step S_SAW      = 4'd9;
    localparam t_step S_DRAIN    = 4'd10;
    localparam t_step S_MAG      = 4'd11;
    localparam t_step S_SC_LO    = 4'd12;
    localparam t_step S_SC_HI    = 4'd13;
    localparam t_step S_ROUND    = 4'd14;
    localparam t_step S_OUT      = 4'd15;

    typedef logic [2:0] t_br;
    localparam t_br BR_NEXT     = 3'd0;
    localparam t_br BR_JUMP     = 3'd1;
    localparam t_br BR_MODE     = 3'd2;
    localparam t_br BR_LOOP     = 3'd3;
    localparam t_br BR_WAIT_IN  = 3'd4;
    localparam t_br BR_WAIT_OUT = 3'd5;

    typedef logic [2:0] t_res;
    localparam t_res RES_NONE  = 3'd0;
    localparam t_res RES_ZERO  = 3'd1;
    localparam t_res RES_SINE  = 3'd2;
    localparam t_res RES_SQR   = 3'd3;
    localparam t_res RES_TRI   = 3'd4;
    localparam t_res RES_NOISE = 3'd5;
    localparam t_res RES_SAW   = 3'd6;

    typedef logic [1:0] t_mb;
    localparam t_mb MB_TERM = 2'd0;
    localparam t_mb MB_LO   = 2'd1;
    localparam t_mb MB_HI   = 2'd2;

    typedef struct packed {
        t_br   br;
        t_step target;
        t_res  res;
        logic  phase_ld;
        logic  saw_run;
        logic  mag_ld;
        t_mb   mb_sel;
        logic  scl_ld;
    } t_ucode;

    typedef struct packed {
        logic              in_valid;
        logic              out_free;
        logic              loop_go;
        logic [MODE_W-1:0] mode;
    } t_seq_stat;

    typedef struct packed {
        t_step  step;
        t_ucode uw;
    } t_seq_ctrl;

    function automatic t_ucode ucode_rom(input t_step s);
        t_ucode u;
        u = '{br: BR_NEXT, target: S_IDLE, res: RES_NONE, phase_ld: 1'b0,
              saw_run: 1'b0, mag_ld: 1'b0, mb_sel: MB_TERM, scl_ld: 1'b0};
        unique case (s)
            S_IDLE: begin
                u.br = BR_WAIT_IN;
                u.target = S_PHASE;
            end
            S_PHASE: begin
                u.br = BR_MODE;
                u.phase_ld = 1'b1;
            end
            S_SINE:     u.br = BR_NEXT;
            S_SINE_RES: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_SINE;
            end
            S_SQR:      u.br = BR_NEXT;
            S_SQR_RES: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_SQR;
            end
            S_TRI: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_TRI;
            end
            S_NOISE: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_NOISE;
            end
            S_ZERO: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_ZERO;
            end
            S_SAW: begin
                u.br = BR_LOOP;
                u.saw_run = 1'b1;
            end
            S_DRAIN:    u.br = BR_NEXT;
            S_MAG: begin
                u.br = BR_NEXT;
                u.mag_ld = 1'b1;
            end
            S_SC_LO: begin
                u.br = BR_NEXT;
                u.mb_sel = MB_LO;
            end
            S_SC_HI: begin
                u.br = BR_NEXT;
                u.mb_sel = MB_HI;
                u.scl_ld = 1'b1;
            end
            S_ROUND: begin
                u.br = BR_JUMP;
                u.target = S_OUT;
                u.res = RES_SAW;
            end
            S_OUT: begin
                u.br = BR_WAIT_OUT;
                u.target = S_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic t_step mode_entry(input logic [MODE_W-1:0] mode);
        t_step s;
        unique case (mode)
            MODE_SINE:   s = S_SINE;
            MODE_SQUARE: s = S_SQR;
            MODE_TRI:    s = S_TRI;
            MODE_NOISE:  s = S_NOISE;
            MODE_SAW:    s = S_SAW;
            default:     s = S_ZERO;
        endcase
        return s;
    endfunction

endpackage

// ===== design/awo_in_if.sv =====
interface awo_in_if import awo_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// ===== design/awo_out_if.sv =====
interface awo_out_if import awo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== design/awo_seq.sv =====
module awo_seq import awo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seq_stat i_stat,
    output t_seq_ctrl o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_ucode w_uw;

    assign w_uw = ucode_rom(r_step);

    always_comb begin
        unique case (w_uw.br)
            BR_NEXT:     n_step = r_step + STEP_W'(1);
            BR_JUMP:     n_step = w_uw.target;
            BR_MODE:     n_step = mode_entry(i_stat.mode);
            BR_LOOP:     n_step = i_stat.loop_go ? r_step : r_step + STEP_W'(1);
            BR_WAIT_IN:  n_step = i_stat.in_valid ? w_uw.target : r_step;
            BR_WAIT_OUT: n_step = i_stat.out_free ? w_uw.target : r_step;
            default:     n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.step = r_step;
    assign o_ctrl.uw   = w_uw;

endmodule

// ===== design/audio_waveform_oscillator.sv =====
// Waveform oscillator. Each item on i_sample carries a sample index; the
// block answers with exactly one item on o_sample, a signed Q2.15 sample of
// the waveform chosen by wave_mode at phase = phase_increment * index.
// Registers are written on the cfg port (index 0 mode, 1 increment,
// 2 harmonic limit); the user must write them only while no item is
// in flight, as the block itself does not enforce it.
// A microcoded sequencer runs one item at a time. After the phase step,
// silence, triangle and noise give their result directly, sine and
// square after the parabola stage, and the sawtooth after summing
// harmonics 1 to L - 1, L = harmonic_limit clamped to 64, one harmonic
// per cycle through the sine and reciprocal multipliers, then drain,
// magnitude, two scale multiplies and rounding.
// A new item can be taken in the cycle after the result enters the output
// register.
// When the receiver stalls, the result waits in the output register and
// the next item is still accepted and worked; it holds until the slot frees.
// Reset restores the register defaults and the noise seed, and empties
// the output register.
`include "audio_waveform_oscillator_macros.svh"

module audio_waveform_oscillator import awo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    awo_in_if.sink                i_sample,
    awo_out_if.source             o_sample
);

    logic [MODE_W-1:0]   r_mode;
    logic [PHASE_W-1:0]  r_inc;
    logic [LIMREG_W-1:0] r_lim;
    logic [31:0]         r_lfsr;

    logic [INDEX_W-1:0]  r_idx;
    logic [PHASE_W-1:0]  r_phase;
    logic [PHASE_W-1:0]  r_p;
    logic [LIM_W-1:0]    r_n;

    logic [31:0]         r_sq;
    logic                r_a_neg;
    logic                r_a_vld;
    logic [IDX_W-1:0]    r_a_n;

    logic [TERM_W-1:0]   r_term;
    logic                r_b_neg;
    logic                r_b_vld;

    logic [ACC_W-1:0]    r_acc;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic [SC_LO_P_W-1:0] r_scl;

    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_data;

    t_seq_stat w_stat;
    t_seq_ctrl w_ctrl;

    logic [LIM_W-1:0]    w_lim_ext;
    logic [LIM_W-1:0]    w_lim;
    logic                w_loop_go;
    logic                w_issue;
    logic                w_out_free;
    logic                w_out_ld;
    logic                w_in_fire;

    logic [PHASE_W-1:0]  w_phase_prod;
    logic [14:0]         w_h;
    logic [16:0]         w_par;
    logic [31:0]         n_sq;
    logic [31:0]         w_sq_rnd;
    logic [15:0]         w_m;

    logic [RECIP_W-1:0]  w_recip_tab [MAX_HARMONICS];
    logic [SCALE_W-1:0]  w_mb_x;
    logic [RECIP_W-1:0]  w_mb_y;
    logic [TERM_W-1:0]   n_term;

    logic [ACC_W-1:0]    w_term_ext;
    logic [ACC_W-1:0]    w_acc_abs;

    logic [SUM_W-1:0]    w_sum;
    logic [RND_W-1:0]    w_rnd;
    logic signed [SAMPLE_W-1:0] w_saw;
    logic signed [SAMPLE_W-1:0] w_sin;
    logic signed [SAMPLE_W-1:0] w_sqr;
    logic signed [SAMPLE_W-1:0] w_tri;
    logic [17:0]         w_u2;
    logic [31:0]         w_lfsr_n;
    logic signed [SAMPLE_W-1:0] w_noise;

    // reciprocal table, floor((2^24 + n/2) / n)
    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_recip
        localparam int RDIV = (g == 0) ? 1 : g;
        localparam int RVAL = ((1 << 24) + RDIV / 2) / RDIV;
        assign w_recip_tab[g] = RECIP_W'(RVAL);
    end

    // sequencer
    assign w_in_fire  = i_sample.valid && i_sample.ready;
    assign w_out_free = !r_out_vld || o_sample.ready;
    assign w_out_ld   = (w_ctrl.uw.br == BR_WAIT_OUT) && w_out_free;

    assign w_lim_ext = LIM_W'(r_lim);
    assign w_lim     = (w_lim_ext > LIM_W'(MAX_HARMONICS)) ? LIM_W'(MAX_HARMONICS)
                                                           : w_lim_ext;
    assign w_loop_go = r_n < w_lim;
    assign w_issue   = w_ctrl.uw.saw_run && w_loop_go;

    assign w_stat.in_valid = i_sample.valid;
    assign w_stat.out_free = w_out_free;
    assign w_stat.loop_go  = w_loop_go;
    assign w_stat.mode     = r_mode;

    awo_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    assign i_sample.ready = (w_ctrl.uw.br == BR_WAIT_IN);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RST_MODE;
            r_inc  <= RST_INC;
            r_lim  <= RST_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_INC:  r_inc  <= i_cfg_data[PHASE_W-1:0];
                CFG_LIM:  r_lim  <= i_cfg_data[LIMREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // phase and harmonic stepping
    assign w_phase_prod = r_inc * r_idx;

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_idx <= i_sample.sample_index;
        end
        if (w_ctrl.uw.phase_ld) begin
            r_phase <= w_phase_prod;
            r_p     <= w_phase_prod;
            r_n     <= LIM_W'(1);
        end else if (w_issue) begin
            r_p <= r_p + r_phase;
            r_n <= r_n + LIM_W'(1);
        end
    end

    // stage A: parabola h * (65536 - 2h)
    assign w_h   = r_p[30:16];
    assign w_par = 17'd65536 - {1'b0, w_h, 1'b0};
    assign n_sq  = {17'd0, w_h} * {15'd0, w_par};

    assign w_sq_rnd = r_sq + 32'd8192;
    assign w_m      = w_sq_rnd[29:14];

    // stage B: shared multiplier, harmonic term or output scaling
    always_comb begin
        unique case (w_ctrl.uw.mb_sel)
            MB_LO: begin
                w_mb_x = SAW_SCALE;
                w_mb_y = RECIP_W'(r_mag[SC_LO_W-1:0]);
            end
            MB_HI: begin
                w_mb_x = SAW_SCALE;
                w_mb_y = RECIP_W'(r_mag[MAG_W-1:SC_LO_W]);
            end
            default: begin
                w_mb_x = w_m;
                w_mb_y = w_recip_tab[r_a_n];
            end
        endcase
    end
    assign n_term = TERM_W'(w_mb_x) * TERM_W'(w_mb_y);

    always_ff @(posedge i_clk) begin
        r_sq    <= n_sq;
        r_a_neg <= r_p[31];
        r_a_n   <= r_n[IDX_W-1:0];
        r_term  <= n_term;
        r_b_neg <= r_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= w_issue;
            r_b_vld <= r_a_vld;
        end
    end

    // accumulate and take magnitude
    assign w_term_ext = ACC_W'(r_term);
    assign w_acc_abs  = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.uw.phase_ld) begin
            r_acc <= '0;
        end else if (r_b_vld) begin
            r_acc <= r_b_neg ? (r_acc - w_term_ext) : (r_acc + w_term_ext);
        end
        if (w_ctrl.uw.mag_ld) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= w_acc_abs[MAG_W-1:0];
        end
        if (w_ctrl.uw.scl_ld) begin
            r_scl <= r_term[SC_LO_P_W-1:0];
        end
    end

    // sawtooth rounding and saturation
    assign w_sum = (SUM_W'(r_term[SC_HI_P_W-1:0]) << SC_LO_W) + SUM_W'(r_scl)
                 + (SUM_W'(1) << (RND_SH - 1));
    assign w_rnd = w_sum[SUM_W-1:RND_SH];

    always_comb begin
        if (!r_neg) begin
            w_saw = (w_rnd > RND_W'(OUT_MAX)) ? SAMPLE_W'(OUT_MAX)
                                              : SAMPLE_W'(w_rnd[SAMPLE_W-1:0]);
        end else begin
            w_saw = (w_rnd > RND_W'(OUT_NEG_MAX))
                  ? SAMPLE_W'(0) - SAMPLE_W'(OUT_NEG_MAX)
                  : SAMPLE_W'(0) - w_rnd[SAMPLE_W-1:0];
        end
    end

    // sine, square, triangle and noise waveforms
    assign w_sin = r_a_neg ? (SAMPLE_W'(0) - SAMPLE_W'(w_m)) : SAMPLE_W'(w_m);
    assign w_sqr = (!r_a_neg && (w_m != 16'd0)) ? 17'sh08000 : 17'sh18000;

    assign w_u2 = {1'b0, r_phase[31:16], 1'b0};
    always_comb begin
        priority if (r_phase[31:30] == 2'b00) begin
            w_tri = w_u2[SAMPLE_W-1:0];
        end else if (r_phase[31:30] != 2'b11) begin
            w_tri = SAMPLE_W'(18'd65536 - w_u2);
        end else begin
            w_tri = SAMPLE_W'(w_u2 - 18'd131072);
        end
    end

    assign w_lfsr_n = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? NOISE_TAPS : 32'd0);
    assign w_noise  = {1'b0, w_lfsr_n[31:16]} - 17'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= NOISE_SEED;
        end else if (w_ctrl.uw.res == RES_NOISE) begin
            r_lfsr <= w_lfsr_n;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.uw.res)
            RES_ZERO:  r_res <= '0;
            RES_SINE:  r_res <= w_sin;
            RES_SQR:   r_res <= w_sqr;
            RES_TRI:   r_res <= w_tri;
            RES_NOISE: r_res <= w_noise;
            RES_SAW:   r_res <= w_saw;
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_ld) begin
            r_out_vld <= 1'b1;
        end else if (o_sample.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_data <= r_res;
        end
    end

    assign o_sample.valid        = r_out_vld;
    assign o_sample.sample_value = r_out_data;

    `AWO_ASSERT_NEXT(a_accept_starts, w_in_fire, w_ctrl.step == S_PHASE, "item not started")
    `AWO_ASSERT_SAME(a_pipe_drained, w_ctrl.uw.mag_ld, !r_a_vld && !r_b_vld, "terms in flight")
    `AWO_ASSERT_SAME(a_lfsr_live, 1'b1, r_lfsr != 32'd0, "noise register stuck at zero")
    `AWO_ASSERT_NEXT(a_out_load, w_out_ld, o_sample.valid && (r_out_data == $past(r_res)), "bad load")

endmodule

// ===== verif/awo_sample_checker.sv =====
`timescale 1ns / 1ps

module awo_sample_checker import awo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [INDEX_W-1:0]         i_in_index,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] i_out_value,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);

    localparam logic [63:0] TWO_OVER_PI_Q16 = 64'd41722;
    localparam logic [31:0] LFSR_SEED       = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_TAPS       = 32'h80200003;
    localparam int          SAMPLE_HI       = 65535;
    localparam int          SAMPLE_LO       = -65536;

    logic [MODE_W-1:0]          cur_mode;
    logic [PHASE_W-1:0]         cur_inc;
    logic [LIMREG_W-1:0]        cur_limit;
    logic [31:0]                lfsr;
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                         err_count;
    int                         seen_count;

    function automatic int sine_q15(input logic [31:0] phase);
        logic [15:0] u;
        longint      h;
        longint      m;
        u = phase[31:16];
        h = longint'({49'd0, u[14:0]});
        m = (h * (65536 - 2 * h) + 8192) >>> 14;
        return u[15] ? -int'(m) : int'(m);
    endfunction

    function automatic int tri_q15(input logic [31:0] phase);
        int u;
        u = int'({16'd0, phase[31:16]});
        if (u < 16384)
            return 2 * u;
        if (u < 49152)
            return 65536 - 2 * u;
        return 2 * u - 131072;
    endfunction

    function automatic int saw_q15(input logic [31:0] phase, input logic [LIMREG_W-1:0] limit);
        int          lim;
        int          n;
        longint      acc;
        longint      recip;
        longint      val;
        logic [63:0] prod;
        logic [63:0] mag;
        logic [63:0] r;
        bit          neg;
        lim = (int'(limit) > MAX_HARMONICS) ? MAX_HARMONICS : int'(limit);
        acc = 0;
        for (n = 1; n < lim; n++) begin
            prod  = 64'(n) * {32'd0, phase};
            recip = longint'((16777216 + n / 2) / n);
            acc  += longint'(sine_q15(prod[31:0])) * recip;
        end
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        r   = (mag * TWO_OVER_PI_Q16 + (64'd1 << 39)) >> 40;
        val = neg ? -longint'(r) : longint'(r);
        if (val > SAMPLE_HI)
            val = SAMPLE_HI;
        if (val < SAMPLE_LO)
            val = SAMPLE_LO;
        return int'(val);
    endfunction

    always @(posedge i_clk) begin
        int                         v;
        logic [31:0]                phase;
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            cur_mode   = MODE_SILENT;
            cur_inc    = 32'd683565276;
            cur_limit  = 7'd50;
            lfsr       = LFSR_SEED;
            expected_samples.delete();
            err_count  = 0;
            seen_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: cur_mode  = i_cfg_data[MODE_W-1:0];
                    CFG_INC:  cur_inc   = i_cfg_data[PHASE_W-1:0];
                    CFG_LIM:  cur_limit = i_cfg_data[LIMREG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                phase = cur_inc * i_in_index;
                case (cur_mode)
                    MODE_SINE:   v = sine_q15(phase);
                    MODE_SQUARE: v = (sine_q15(phase) > 0) ? 32768 : -32768;
                    MODE_TRI:    v = tri_q15(phase);
                    MODE_NOISE: begin
                        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                        v = int'({16'd0, lfsr[31:16]}) - 32768;
                    end
                    MODE_SAW:    v = saw_q15(phase, cur_limit);
                    default:     v = 0;
                endcase
                expected_samples.push_back(v[SAMPLE_W-1:0]);
            end
            if (i_out_valid && i_out_ready) begin
                seen_count++;
                if (expected_samples.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("checker: sample %0d arrived with none expected",
                                 i_out_value);
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out_value !== want) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("checker: sample_value expected %0d, got %0d",
                                     want, i_out_value);
                    end
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_samples.size();
        o_results <= seen_count;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import awo_pkg::*;

    localparam int                   ITEM_TARGET = 1250;
    localparam int                   STALL_LIMIT = 2000;
    localparam int                   TAIL_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    awo_in_if  in_ch ();
    awo_out_if out_ch ();

    int errors;
    int pending;
    int results;
    int items_sent   = 0;
    int settings     = 0;
    int idle_cycles  = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    audio_waveform_oscillator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (in_ch),
        .o_sample   (out_ch)
    );

    awo_sample_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_index  (in_ch.sample_index),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_value (out_ch.sample_value),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each item, none when rx_steady is set
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [MODE_W-1:0] mode, input logic [PHASE_W-1:0] inc,
                            input logic [LIMREG_W-1:0] lim);
        logic [CFG_DATA_W-1:0] mode_word;
        logic [CFG_DATA_W-1:0] lim_word;
        mode_word = $urandom_range(0, 1) ? $urandom : 32'd0;
        lim_word  = $urandom_range(0, 1) ? $urandom : 32'd0;
        mode_word[MODE_W-1:0]   = mode;
        lim_word[LIMREG_W-1:0]  = lim;
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_INC, inc);
        write_reg(CFG_LIM, lim_word);
        if ($urandom_range(0, 1))
            write_reg(CFG_NONE, $urandom);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_item(input logic [INDEX_W-1:0] index);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_index <= index;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold off until every result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [MODE_W-1:0]   mode;
        logic [PHASE_W-1:0]  inc;
        logic [LIMREG_W-1:0] lim;
        logic [INDEX_W-1:0]  index;
        int                  count;
        int                  pause_at;
        int                  k;
        bit                  running;
        bit                  first;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_MODE;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_index <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset
        send_item(32'd0);
        send_item(32'hFFFF_FFFF);
        drain_results();
        write_reg(CFG_MODE, {29'd0, MODE_SINE});
        i_cfg_we <= 1'b0;
        send_item(32'd1);
        send_item(32'h1234_5678);
        drain_results();
        write_reg(CFG_MODE, {29'd0, MODE_SAW});
        i_cfg_we <= 1'b0;
        send_item(32'd3);
        drain_results();

        // quarter-cycle phases: peak, negative zero, trough
        set_regs(MODE_SINE, 32'h4000_0000, 7'd50);
        send_item(32'd1);
        send_item(32'd2);
        send_item(32'd3);
        drain_results();
        set_regs(MODE_SQUARE, 32'h4000_0000, 7'd50);
        send_item(32'd0);
        send_item(32'd1);
        send_item(32'd3);
        drain_results();
        set_regs(MODE_TRI, 32'h4000_0000, 7'd50);
        send_item(32'd1);
        send_item(32'd3);
        drain_results();
        set_regs(MODE_TRI, 32'hFFFF_FFFF, 7'd50);
        send_item(32'hFFFF_FFFF);
        drain_results();
        set_regs(MODE_NOISE, 32'd0, 7'd50);
        send_item(32'd0);
        send_item($urandom);
        send_item(32'hFFFF_FFFF);
        drain_results();
        set_regs(MODE_SAW, 32'h0100_0000, 7'd0);
        send_item(32'd5);
        drain_results();
        set_regs(MODE_SAW, 32'h0100_0000, 7'd1);
        send_item(32'd5);
        drain_results();
        set_regs(MODE_SAW, 32'h0100_0000, 7'd64);
        send_item(32'd5);
        drain_results();
        set_regs(MODE_SAW, 32'hFFFF_FFFF, 7'd127);
        send_item(32'd7);
        drain_results();
        set_regs(3'd6, $urandom, 7'd9);
        send_item($urandom);
        drain_results();
        set_regs(3'd7, $urandom, 7'd9);
        send_item($urandom);
        drain_results();

        first = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            mode = MODE_W'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0:       inc = 32'd0;
                1:       inc = 32'hFFFF_FFFF;
                2:       inc = $urandom_range(1, 1 << 20);
                default: inc = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       lim = LIMREG_W'($urandom_range(65, 127));
                1:       lim = 7'd64;
                2:       lim = LIMREG_W'($urandom_range(0, 2));
                default: lim = LIMREG_W'($urandom_range(3, 16));
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            set_regs(mode, inc, lim);
            count    = $urandom_range(20, 60);
            pause_at = (first || $urandom_range(0, 3) == 0) ? $urandom_range(1, count - 1) : -1;
            first    = 1'b0;
            running  = ($urandom_range(0, 3) != 0);
            index    = $urandom;
            for (k = 0; k < count; k++) begin
                if (k == pause_at)
                    drain_results();
                if (running) begin
                    index = index + 1;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       index = 32'd0;
                        1:       index = 32'hFFFF_FFFF;
                        2:       index = $urandom_range(0, 255);
                        default: index = $urandom;
                    endcase
                end
                send_item(index);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("tb: %0d items sent, %0d samples checked, %0d register settings",
                 items_sent, results, settings);
        $display("tb: covered all modes incl. unused codes, limits 0..127, gaps and stalls");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/awo_pkg.sv
design/awo_in_if.sv
design/awo_out_if.sv
design/awo_seq.sv
design/audio_waveform_oscillator.sv
verif/awo_sample_checker.sv
verif/tb.sv
